/* src/tmbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torch mode button controller package
// Shared widths, mode codes, register indexes, reset values and types.
// ----------------------------------------------------------------------------
package tmbc_pkg;

    localparam int unsigned MODE_W      = 3;
    localparam int unsigned LED_CNT_W   = 2;
    localparam int unsigned HOLD_W      = 12;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam int unsigned SUB_W       = 7;
    localparam int unsigned HUND_W      = 6;

    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ONE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TWO    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_THREE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STROBE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FLASH  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_MAX    = MODE_FLASH;

    localparam logic [CFG_IDX_W-1:0] REG_MODE_COUNT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_LIMIT = 2'd2;

    localparam logic [MODE_W-1:0]    MODE_COUNT_RST = 3'd5;
    localparam logic [LED_CNT_W-1:0] LED_COUNT_RST  = 2'd3;
    localparam logic [HOLD_W-1:0]    LONG_PRESS_RST = 12'd3000;
    localparam logic [HOLD_W-1:0]    HOLD_SAT       = 12'd4095;

    // The phase runs modulo 4400 ms as a millisecond count within each
    // 100 ms step and a count of 100 ms steps.
    localparam logic [SUB_W-1:0]  SUB_LAST  = 7'd99;
    localparam logic [HUND_W-1:0] HUND_LAST = 6'd43;

    typedef struct packed {
        logic three;
        logic two;
        logic one;
    } led_drive_t;

endpackage

/* src/torch_mode_button_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torch mode button controller
// Counts button releases into a torch mode, returning to off after a long hold, and drives three LEDs from it.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the button level and
// produces exactly one result transfer, in the cycle after acceptance, with
// the LED levels and the mode after that tick. A transfer can be accepted in
// every cycle while the output is not stalled; the single result register,
// which may hold a result while the next tick is taken when the output is
// being drained, sets that figure. Configuration writes are taken at any time.
module torch_mode_button_controller_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] button_level, [7:1] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] led_one, [1] led_two, [2] led_three,
                                  // [5:3] current_mode, [7:6] zero
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tmbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmbc_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [tmbc_pkg::MODE_W-1:0]    mode_count_reg;
    logic [tmbc_pkg::LED_CNT_W-1:0] led_count_reg;
    logic [tmbc_pkg::HOLD_W-1:0]    long_press_limit_reg;

    logic                        held_level_reg, held_level_next;
    logic [tmbc_pkg::HOLD_W-1:0] hold_time_reg, hold_time_next;
    logic [tmbc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [tmbc_pkg::SUB_W-1:0]  phase_sub_reg, phase_sub_next;
    logic [tmbc_pkg::HUND_W-1:0] phase_hund_reg, phase_hund_next;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    logic                        level;
    logic                        accept;
    logic [tmbc_pkg::MODE_W-1:0] top_mode;
    logic [tmbc_pkg::MODE_W:0]   mode_inc;
    logic [tmbc_pkg::HOLD_W-1:0] hold_inc;
    tmbc_pkg::led_drive_t        leds;

    assign level     = s_tdata[0];
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign top_mode = (mode_count_reg > tmbc_pkg::MODE_MAX) ? tmbc_pkg::MODE_MAX
                                                            : mode_count_reg;
    assign mode_inc = {1'b0, mode_reg} + 4'd1;
    assign hold_inc = (hold_time_reg == tmbc_pkg::HOLD_SAT) ? hold_time_reg
                                                            : hold_time_reg + 12'd1;

    always_comb begin
        held_level_next = held_level_reg;
        hold_time_next  = hold_time_reg;
        mode_next       = mode_reg;
        if (level && !held_level_reg) begin
            hold_time_next  = '0;
            held_level_next = 1'b1;
        end else if (!level && held_level_reg) begin
            mode_next = (mode_inc > {1'b0, top_mode}) ? tmbc_pkg::MODE_OFF
                                                      : mode_inc[tmbc_pkg::MODE_W-1:0];
            held_level_next = 1'b0;
        end else if (held_level_reg) begin
            hold_time_next = hold_inc;
            if (hold_inc > long_press_limit_reg) begin
                mode_next = tmbc_pkg::MODE_OFF;
            end
        end
    end

    always_comb begin
        phase_sub_next  = phase_sub_reg + 7'd1;
        phase_hund_next = phase_hund_reg;
        if (phase_sub_reg == tmbc_pkg::SUB_LAST) begin
            phase_sub_next  = '0;
            phase_hund_next = (phase_hund_reg == tmbc_pkg::HUND_LAST) ? '0
                                                                      : phase_hund_reg + 6'd1;
        end
    end

    tmbc_led_decode u_led_decode (
        .mode       (mode_next),
        .led_count  (led_count_reg),
        .phase_hund (phase_hund_reg),
        .leds       (leds)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_count_reg       <= tmbc_pkg::MODE_COUNT_RST;
            led_count_reg        <= tmbc_pkg::LED_COUNT_RST;
            long_press_limit_reg <= tmbc_pkg::LONG_PRESS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tmbc_pkg::REG_MODE_COUNT:
                    mode_count_reg <= cfg_data[tmbc_pkg::MODE_W-1:0];
                tmbc_pkg::REG_LED_COUNT:
                    led_count_reg <= cfg_data[tmbc_pkg::LED_CNT_W-1:0];
                tmbc_pkg::REG_LONG_PRESS_LIMIT:
                    long_press_limit_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_level_reg <= 1'b0;
            hold_time_reg  <= '0;
            mode_reg       <= tmbc_pkg::MODE_OFF;
            phase_sub_reg  <= '0;
            phase_hund_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                held_level_reg <= held_level_next;
                hold_time_reg  <= hold_time_next;
                mode_reg       <= mode_next;
                phase_sub_reg  <= phase_sub_next;
                phase_hund_reg <= phase_hund_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {2'b00, mode_next, leds.three, leds.two, leds.one};
        end
    end

endmodule

/* src/tmbc_led_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torch mode LED decoder
// Drives the three LEDs from the mode, the fitted LED count and the phase.
// ----------------------------------------------------------------------------
module tmbc_led_decode (
    input  logic [tmbc_pkg::MODE_W-1:0]    mode,
    input  logic [tmbc_pkg::LED_CNT_W-1:0] led_count,
    input  logic [tmbc_pkg::HUND_W-1:0]    phase_hund,
    output tmbc_pkg::led_drive_t           leds
);

    logic [tmbc_pkg::LED_CNT_W-1:0] fitted;
    logic [tmbc_pkg::HUND_W-2:0]    slot;
    logic                           flash_on;

    assign fitted = (led_count == 2'd0) ? 2'd1 : led_count;
    assign slot   = phase_hund[tmbc_pkg::HUND_W-1:1];

    always_comb begin
        case (slot)
            5'd0, 5'd2, 5'd4, 5'd8, 5'd9, 5'd10, 5'd12, 5'd13, 5'd14,
            5'd16, 5'd17, 5'd18: flash_on = 1'b1;
            default:             flash_on = 1'b0;
        endcase
    end

    always_comb begin
        leds = '0;
        unique case (mode)
            tmbc_pkg::MODE_ONE: begin
                leds.one = 1'b1;
            end
            tmbc_pkg::MODE_TWO: begin
                leds.one = (fitted == 2'd1);
                leds.two = (fitted == 2'd2);
            end
            tmbc_pkg::MODE_THREE: begin
                leds.one   = (fitted == 2'd1);
                leds.two   = (fitted == 2'd2);
                leds.three = (fitted == 2'd3);
            end
            tmbc_pkg::MODE_STROBE: begin
                leds.one = phase_hund[0];
            end
            tmbc_pkg::MODE_FLASH: begin
                leds.one = flash_on;
            end
            default: begin
                leds = '0;
            end
        endcase
    end

endmodule

/* src/tmbc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torch mode button controller checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tmbc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result transfer changed.");

    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:3] <= tmbc_pkg::MODE_MAX)
        else $error("Mode out of range.");

    a_off_is_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:3] == tmbc_pkg::MODE_OFF |-> m_tdata[2:0] == 3'b000)
        else $error("LED lit while off.");

    a_single_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[2:0]))
        else $error("More than one LED lit.");

endmodule

bind torch_mode_button_controller_top tmbc_checker u_tmbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
